### rtl/nus_pkg.sv
// Shared types, constants and the bit-reverse helper function of the Owen scrambler.
package nus_pkg;

    localparam int LANE_W               = 2;
    localparam int LANES_PER_GROUP_DEF  = 4;
    localparam int LK_ROUNDS            = 4;

    localparam logic [63:0] MIX_MUL    = 64'h0e9846af9b1a615d;
    localparam logic [31:0] MIX_MUL_LO = MIX_MUL[31:0];
    localparam logic [31:0] MIX_MUL_HI = MIX_MUL[63:32];
    localparam logic [63:0] GOLDEN     = 64'h000000009e3779b9;

    localparam logic [0:LK_ROUNDS-1][31:0] LK_KEY = {
        32'h6c50b47c, 32'hb82f1e52, 32'hc7afe638, 32'h8d22f6e6
    };

    typedef struct packed {
        logic              cmd;
        logic [31:0]       raw_value;
        logic [31:0]       group_seed;
        logic [LANE_W-1:0] lane;
    } in_t;

    typedef struct packed {
        logic [31:0] scrambled_value;
    } out_t;

    // item context carried down the seed pipeline; s is the running seed
    typedef struct packed {
        logic              cmd;
        logic [31:0]       raw_value;
        logic [31:0]       group_seed;
        logic [LANE_W-1:0] lane;
        logic [63:0]       s;
    } ctx_t;

    typedef struct packed {
        ctx_t        ctx;
        logic [63:0] w;
    } work_t;

    function automatic logic [31:0] rev32(input logic [31:0] x);
        logic [31:0] r;
        for (int i = 0; i < 32; i++)
        begin
            r[i] = x[31-i];
        end
        return r;
    endfunction

endpackage

### rtl/nus_stream_if.sv
// Valid/ready stream channel carrying one payload item.
interface nus_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/nus_mul64.sv
// Three-stage 64-bit multiply by the mix constant, built from 32-bit partial products.
module nus_mul64
    import nus_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    nus_stream_if.sink    up,
    nus_stream_if.source  dn
);

    logic        v1_reg, v2_reg, v3_reg;
    ctx_t        c1_reg, c2_reg;
    logic [63:0] x1_reg;
    logic [63:0] p1_reg;
    logic [31:0] lo2_reg, hi2_reg, xl2_reg;
    work_t       d3_reg;

    logic rdy1, rdy2, rdy3;

    logic [63:0] p1_next;
    logic [31:0] hi2_next;
    work_t       d3_next;

    assign rdy3     = !v3_reg || dn.ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign up.ready = rdy1;

    assign p1_next  = {32'b0, up.data.w[31:0]} * {32'b0, MIX_MUL_LO};
    assign hi2_next = p1_reg[63:32] + 32'(x1_reg[63:32] * MIX_MUL_LO);

    always_comb
    begin
        d3_next.ctx = c2_reg;
        d3_next.w   = {hi2_reg + 32'(xl2_reg * MIX_MUL_HI), lo2_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= up.valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && up.valid)
        begin
            c1_reg <= up.data.ctx;
            x1_reg <= up.data.w;
            p1_reg <= p1_next;
        end
        if (rdy2 && v1_reg)
        begin
            c2_reg  <= c1_reg;
            lo2_reg <= p1_reg[31:0];
            hi2_reg <= hi2_next;
            xl2_reg <= x1_reg[31:0];
        end
        if (rdy3 && v2_reg)
        begin
            d3_reg <= d3_next;
        end
    end

    assign dn.valid = v3_reg;
    assign dn.data  = d3_reg;

endmodule

### rtl/nus_mix_round.sv
// One 64-bit hash-combine round of the lane seed derivation, nine stages deep.
module nus_mix_round
    import nus_pkg::*;
#(
    parameter int ROUND = 0
)
(
    input  logic          clk,
    input  logic          rst_n,
    nus_stream_if.sink    up,
    nus_stream_if.source  dn
);

    nus_stream_if #(.payload_t(work_t)) la ();
    nus_stream_if #(.payload_t(work_t)) lm0 ();
    nus_stream_if #(.payload_t(work_t)) lb ();
    nus_stream_if #(.payload_t(work_t)) lm1 ();

    logic  va_reg, vb_reg, vc_reg;
    work_t da_reg, db_reg, dc_reg;
    work_t da_next, db_next, dc_next;
    logic [63:0] y;
    logic        act;

    // stage A: add golden ratio and round index, fold high half
    always_comb
    begin
        y           = up.data.ctx.s + GOLDEN + 64'(ROUND);
        da_next.ctx = up.data.ctx;
        da_next.w   = y ^ (y >> 32);
    end

    assign up.ready = !va_reg || la.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else if (up.ready)
        begin
            va_reg <= up.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up.ready && up.valid)
        begin
            da_reg <= da_next;
        end
    end

    assign la.valid = va_reg;
    assign la.data  = da_reg;

    nus_mul64 u_mul0 (.clk(clk), .rst_n(rst_n), .up(la), .dn(lm0));

    // stage B: fold high half between the two multiplies
    always_comb
    begin
        db_next.ctx = lm0.data.ctx;
        db_next.w   = lm0.data.w ^ (lm0.data.w >> 32);
    end

    assign lm0.ready = !vb_reg || lb.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
        end
        else if (lm0.ready)
        begin
            vb_reg <= lm0.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lm0.ready && lm0.valid)
        begin
            db_reg <= db_next;
        end
    end

    assign lb.valid = vb_reg;
    assign lb.data  = db_reg;

    nus_mul64 u_mul1 (.clk(clk), .rst_n(rst_n), .up(lb), .dn(lm1));

    // stage C: final fold; the seed advances only for derive items up to their lane
    assign act = lm1.data.ctx.cmd && ({1'b0, lm1.data.ctx.lane} >= (LANE_W+1)'(ROUND));

    always_comb
    begin
        dc_next = lm1.data;
        if (act)
        begin
            dc_next.ctx.s = lm1.data.w ^ (lm1.data.w >> 28);
        end
    end

    assign lm1.ready = !vc_reg || dn.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
        end
        else if (lm1.ready)
        begin
            vc_reg <= lm1.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lm1.ready && lm1.valid)
        begin
            dc_reg <= dc_next;
        end
    end

    assign dn.valid = vc_reg;
    assign dn.data  = dc_reg;

endmodule

### rtl/nus_lk_hash.sv
// Laine-Karras hash pipeline: reverse and seed add, four xor-multiply stages, reverse out.
module nus_lk_hash
    import nus_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    nus_stream_if.sink    up,
    nus_stream_if.source  dn
);

    localparam int NS = LK_ROUNDS + 1;

    logic [NS-1:0] v_reg;
    logic [31:0]   x_reg [NS];
    logic [NS:0]   rdy;
    logic [31:0]   seed;
    logic [31:0]   x0_next;

    always_comb
    begin
        rdy[NS] = dn.ready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign up.ready = rdy[0];

    assign seed    = up.data.ctx.cmd ? up.data.ctx.s[31:0] : up.data.ctx.group_seed;
    assign x0_next = rev32(up.data.ctx.raw_value) + seed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= up.valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && up.valid)
        begin
            x_reg[0] <= x0_next;
        end
    end

    for (genvar k = 1; k < NS; k++)
    begin : g_round
        always_ff @(posedge clk)
        begin
            if (rdy[k] && v_reg[k-1])
            begin
                x_reg[k] <= x_reg[k-1] ^ 32'(x_reg[k-1] * LK_KEY[k-1]);
            end
        end
    end

    assign dn.valid                = v_reg[NS-1];
    assign dn.data.scrambled_value = rev32(x_reg[NS-1]);

endmodule

### rtl/nested_uniform_owen_scrambler.sv
// Top level of the nested uniform (Owen) scrambler pipeline.
// One item enters per cycle and one result leaves per cycle, sustained, for any mix of
// commands while result.ready holds. There are R = min(LANES_PER_GROUP, 4) seed rounds;
// each seed round holds two 64-bit multiplies, each cut into three 32-bit partial-product
// stages, and the hash adds five stages. Every item walks all seed rounds; rounds beyond
// its lane, and all rounds for command 0, pass the seed through. Stages hold their item
// under back-pressure and fill bubbles, so an item is taken while a result waits as long
// as any stage is empty.
module nested_uniform_owen_scrambler
    import nus_pkg::*;
#(
    parameter int LANES_PER_GROUP = LANES_PER_GROUP_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    nus_stream_if.sink    item,
    nus_stream_if.source  result
);

    localparam int NR = (LANES_PER_GROUP < (1 << LANE_W)) ? LANES_PER_GROUP : (1 << LANE_W);

    nus_stream_if #(.payload_t(work_t)) link [NR+1] ();

    logic [LANE_W-1:0] lane_mod;
    work_t             head;

    // lane modulo the group size by repeated compare and subtract
    always_comb
    begin
        lane_mod = item.data.lane;
        for (int i = 0; i < (1 << LANE_W) - 1; i++)
        begin
            if (32'(lane_mod) >= LANES_PER_GROUP)
            begin
                lane_mod = LANE_W'(32'(lane_mod) - LANES_PER_GROUP);
            end
        end
    end

    always_comb
    begin
        head.ctx.cmd        = item.data.cmd;
        head.ctx.raw_value  = item.data.raw_value;
        head.ctx.group_seed = item.data.group_seed;
        head.ctx.lane       = lane_mod;
        head.ctx.s          = {32'b0, item.data.group_seed};
        head.w              = '0;
    end

    assign link[0].valid = item.valid;
    assign link[0].data  = head;
    assign item.ready    = link[0].ready;

    for (genvar r = 0; r < NR; r++)
    begin : g_seed
        nus_mix_round #(.ROUND(r)) u_round (
            .clk   (clk),
            .rst_n (rst_n),
            .up    (link[r]),
            .dn    (link[r+1])
        );
    end

    nus_lk_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .up    (link[NR]),
        .dn    (result)
    );

`ifndef NO_ASSERTIONS
    // input only blocks when every stage is full and the result is stalled
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> result.valid && !result.ready)
        else $error("input stalled with a free pipeline stage");

    // index items leave the seed rounds with the group seed untouched
    a_direct_seed: assert property (@(posedge clk) disable iff (!rst_n)
        link[NR].valid && !link[NR].data.ctx.cmd
        |-> link[NR].data.ctx.s == {32'b0, link[NR].data.ctx.group_seed})
        else $error("seed changed for a direct-seed item");

    // seed pipeline holds its item while the hash stage is full
    a_seed_hold: assert property (@(posedge clk) disable iff (!rst_n)
        link[NR].valid && !link[NR].ready
        |=> link[NR].valid && $stable(link[NR].data.ctx))
        else $error("seed pipeline item lost under back-pressure");
`endif

endmodule
